>>> rtl/swt_pkg.sv
package swt_pkg;

    localparam int WORD_STORE  = 256;
    localparam int CNT_W       = $clog2(WORD_STORE);
    localparam int MAX_RES     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] WORD_LIMIT = CNT_W'(WORD_STORE - 1);

    localparam logic [2:0] MATCH_NONE   = 3'd0;
    localparam logic [2:0] MATCH_DONE   = 3'd4;
    localparam logic [2:0] MATCH_BROKEN = 3'd7;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_E     = 8'h65;

    typedef enum logic [1:0] {
        REQ_CHAR  = 2'd0,
        REQ_EOI   = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_STOP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_GT1  = 2'd2,
        MODE_GT2  = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] chr;
        logic [7:0] len;
        logic       pipe;
    } res_t;

    typedef struct packed {
        logic [1:0]               n;
        res_t [MAX_RES-1:0]       res;
    } bundle_t;

    function automatic logic [7:0] stop_char(input logic [1:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                2'd0:    c = CH_D;
                2'd1:    c = CH_O;
                2'd2:    c = CH_N;
                default: c = CH_E;
            endcase
            return c;
        end
    endfunction

    function automatic logic [2:0] store_match(input logic [2:0] m, input logic [7:0] c);
        logic [2:0] r;
        begin
            if (m < MATCH_DONE && c == stop_char(m[1:0]))
                r = m + 3'd1;
            else
                r = MATCH_BROKEN;
            return r;
        end
    endfunction

    function automatic logic [7:0] word_len(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+7:0] tmp;
        begin
            tmp = {8'h00, cnt};
            return tmp[7:0];
        end
    endfunction

    function automatic logic is_break(input logic [7:0] c);
        return c == CH_LT || c == CH_GT || c == CH_PIPE || c == CH_HASH || c == CH_AMP;
    endfunction

endpackage

>>> rtl/swt_front.sv
module swt_front import swt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [7:0] ch,
    input  logic       q_full,
    output logic       q_push,
    output bundle_t    q_data
);

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             esc_reg, esc_next;
    logic [2:0]       match_reg, match_next;
    logic             pipe_reg, pipe_next;

    logic             accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept && (q_data.n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            cnt_reg   <= '0;
            esc_reg   <= 1'b0;
            match_reg <= MATCH_NONE;
            pipe_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            esc_reg   <= esc_next;
            match_reg <= match_next;
            pipe_reg  <= pipe_next;
        end
    end

    always_comb
    begin
        logic [1:0]       n;
        logic             run_idle;
        logic [CNT_W-1:0] cnt_inc;
        logic [2:0]       match_inc;
        res_t             fin;
        res_t             chr_res;

        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        esc_next   = esc_reg;
        match_next = match_reg;
        pipe_next  = pipe_reg;
        q_data     = '0;
        n          = 2'd0;
        run_idle   = 1'b0;
        cnt_inc    = cnt_reg + 1'b1;
        match_inc  = store_match(match_reg, ch);

        fin.kind    = (match_reg == MATCH_DONE) ? KIND_STOP : KIND_END;
        fin.chr     = 8'h00;
        fin.len     = word_len(cnt_reg);
        fin.pipe    = pipe_reg;
        chr_res.kind = KIND_CHAR;
        chr_res.chr  = ch;
        chr_res.len  = 8'h00;
        chr_res.pipe = pipe_reg;

        case (req_type)
            REQ_CLEAR:
            begin
                pipe_next = 1'b0;
            end
            REQ_EOI:
            begin
                if (mode_reg != MODE_IDLE && cnt_reg != '0)
                begin
                    q_data.res[n] = fin;
                    n = n + 2'd1;
                end
                if (!(mode_reg != MODE_IDLE && cnt_reg != '0 && match_reg == MATCH_DONE))
                begin
                    q_data.res[n] = '{kind: KIND_STOP, chr: 8'h00, len: 8'h00, pipe: pipe_reg};
                    n = n + 2'd1;
                end
                mode_next  = MODE_IDLE;
                cnt_next   = '0;
                esc_next   = 1'b0;
                match_next = MATCH_NONE;
            end
            REQ_CHAR:
            begin
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        run_idle = 1'b1;
                    end
                    MODE_WORD:
                    begin
                        if (cnt_reg >= WORD_LIMIT || (ch == CH_NL && cnt_reg != '0)
                            || (!esc_reg && is_break(ch)))
                        begin
                            q_data.res[n] = fin;
                            n = n + 2'd1;
                            run_idle = 1'b1;
                        end
                        else if (ch == CH_NL || (!esc_reg && ch == CH_SPACE))
                        begin
                            q_data.res[n] = fin;
                            n = n + 2'd1;
                            mode_next  = MODE_IDLE;
                            cnt_next   = '0;
                            esc_next   = 1'b0;
                            match_next = MATCH_NONE;
                        end
                        else if (!esc_reg && ch == CH_BSL)
                        begin
                            esc_next = 1'b1;
                        end
                        else
                        begin
                            q_data.res[n] = chr_res;
                            n = n + 2'd1;
                            cnt_next   = cnt_inc;
                            match_next = match_inc;
                            esc_next   = 1'b0;
                        end
                    end
                    MODE_GT1, MODE_GT2:
                    begin
                        if (ch == CH_AMP || (mode_reg == MODE_GT1 && ch == CH_GT))
                        begin
                            q_data.res[n] = chr_res;
                            n = n + 2'd1;
                            cnt_next   = cnt_inc;
                            match_next = match_inc;
                            esc_next   = 1'b0;
                            mode_next  = MODE_GT2;
                            if (ch == CH_AMP)
                            begin
                                q_data.res[n] = '{kind: (match_inc == MATCH_DONE) ? KIND_STOP
                                                        : KIND_END,
                                                  chr: 8'h00, len: word_len(cnt_inc),
                                                  pipe: pipe_reg};
                                n = n + 2'd1;
                                mode_next  = MODE_IDLE;
                                cnt_next   = '0;
                                match_next = MATCH_NONE;
                            end
                        end
                        else
                        begin
                            q_data.res[n] = fin;
                            n = n + 2'd1;
                            run_idle = 1'b1;
                        end
                    end
                    default:
                    begin
                        run_idle = 1'b0;
                    end
                endcase

                if (run_idle)
                begin
                    mode_next  = MODE_IDLE;
                    cnt_next   = '0;
                    esc_next   = 1'b0;
                    match_next = MATCH_NONE;
                    if (ch == CH_PIPE)
                        pipe_next = 1'b1;
                    chr_res.pipe = pipe_next;
                    if (ch == CH_NL)
                    begin
                        q_data.res[n] = '{kind: KIND_END, chr: 8'h00, len: 8'h00,
                                          pipe: pipe_next};
                        n = n + 2'd1;
                    end
                    else if (ch == CH_BSL)
                    begin
                        mode_next = MODE_WORD;
                        esc_next  = 1'b1;
                    end
                    else if (ch != CH_SPACE)
                    begin
                        q_data.res[n] = chr_res;
                        n = n + 2'd1;
                        if (ch == CH_PIPE || ch == CH_LT || ch == CH_AMP)
                        begin
                            q_data.res[n] = '{kind: KIND_END, chr: 8'h00, len: 8'h01,
                                              pipe: pipe_next};
                            n = n + 2'd1;
                        end
                        else
                        begin
                            cnt_next   = CNT_W'(1);
                            match_next = store_match(MATCH_NONE, ch);
                            mode_next  = (ch == CH_GT) ? MODE_GT1 : MODE_WORD;
                        end
                    end
                end
            end
            default:
            begin
                n = 2'd0;
            end
        endcase

        q_data.n = n;
    end

endmodule

>>> rtl/swt_queue.sv
module swt_queue import swt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t wdata,
    input  logic    pop,
    output bundle_t rdata,
    output logic    full,
    output logic    empty
);

    bundle_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty queue");

endmodule

>>> rtl/swt_back.sv
module swt_back import swt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bundle_t    q_data,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] res_kind,
    output logic [7:0] out_char,
    output logic [7:0] word_length,
    output logic       pipe_seen,
    output logic       last
);

    bundle_t    cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    logic       last_reg;

    logic       advance;
    logic       at_last;
    res_t       cur_res;

    assign cur_res = cur_reg.res[idx_reg];
    assign at_last = (idx_reg == cur_reg.n - 2'd1);
    assign advance = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign q_pop   = !q_empty && (!cur_valid_reg || (advance && at_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (advance)
            begin
                if (at_last)
                    cur_valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 2'd1;
            end

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
        if (advance)
        begin
            out_res_reg <= cur_res;
            last_reg    <= at_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign res_kind    = out_res_reg.kind;
    assign out_char    = out_res_reg.chr;
    assign word_length = out_res_reg.len;
    assign pipe_seen   = out_res_reg.pipe;
    assign last        = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) cur_valid_reg |-> cur_reg.n != 2'd0)
        else $error("empty bundle held");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !last_reg) |=> out_valid_reg)
        else $error("result group broken before last");

endmodule

>>> rtl/shell_word_tokenizer_unit.sv
// Shell word tokenizer. One input transfer (a character, end of input, or a pipe-mark clear)
// is taken per clock while the result queue has room, and causes zero to three result
// transfers; the last one of each group carries last. Results leave at one per clock while
// out_stall is low, through a registered output, so a long run of multi-result inputs is
// paced by the output side: a four-entry queue of result groups between the lexer and the
// output serializer absorbs bursts. Results pass the queue, held-group and output registers.
module shell_word_tokenizer_unit import swt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] res_kind,
    output logic [7:0] out_char,
    output logic [7:0] word_length,
    output logic       pipe_seen,
    output logic       last
);

    logic    q_full, q_empty, q_push, q_pop;
    bundle_t q_wdata, q_rdata;

    swt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .ch       (ch),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    swt_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    swt_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_rdata),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .res_kind    (res_kind),
        .out_char    (out_char),
        .word_length (word_length),
        .pipe_seen   (pipe_seen),
        .last        (last)
    );

endmodule
